### hw/rtl/itt_pkg.sv
// Shared types and constants for the INI text tokenizer.
`timescale 1ns / 1ps

package itt_pkg;

    // Default store depths
    localparam int unsigned NAME_DEPTH_DEF  = 32;
    localparam int unsigned VALUE_DEPTH_DEF = 32;

    // Character codes the parser reacts to
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

    typedef enum logic [1:0] {
        KIND_SECTION = 2'd0,
        KIND_KEY     = 2'd1,
        KIND_VALUE   = 2'd2
    } token_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_READ,
        ST_FLUSH
    } state_t;

    // Store port strobes
    typedef struct packed {
        logic name_we;
        logic name_re;
        logic value_we;
        logic value_re;
    } store_ctl_t;

endpackage

### hw/rtl/ini_text_tokenizer.sv
// Top level of the INI text tokenizer: byte parser, report readout and output register.
`timescale 1ns / 1ps

// Channel   Ports                                    Direction  Moves
// -------   ---------------------------------------  ---------  ------------------------
// text      text_valid, text_ready, text_byte        in         one INI byte (0 = end)
// token     token_valid, token_ready, token_kind,     out        one reported character
//           token_char, run_end
//
// Input: a byte that causes no report is taken back to back with the next. A section report
// holds the input through the accept, the first store read, a read per name character and
// the terminator read that releases the last one. A setting adds a read per value character
// and a release step, and skips the terminator read when the name is capped.
// Output stalls hold the readout in place.
// Reset: rst_n clears control and the name-store valid bits at once; no clearing pass.

module ini_text_tokenizer #(
    parameter int unsigned NAME_DEPTH  = itt_pkg::NAME_DEPTH_DEF,
    parameter int unsigned VALUE_DEPTH = itt_pkg::VALUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       text_valid,
    output logic       text_ready,
    input  logic [7:0] text_byte,
    output logic       token_valid,
    input  logic       token_ready,
    output logic [1:0] token_kind,
    output logic [7:0] token_char,
    output logic       run_end
);

    localparam int unsigned MAX_DEPTH = (NAME_DEPTH > VALUE_DEPTH) ? NAME_DEPTH : VALUE_DEPTH;
    localparam int unsigned WP_W      = $clog2(MAX_DEPTH);
    localparam int unsigned NA_W      = $clog2(NAME_DEPTH);
    localparam int unsigned VA_W      = $clog2(VALUE_DEPTH);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    itt_pkg::state_t      state_reg, state_next;
    logic                 in_setting_reg, in_setting_next;
    logic                 in_section_reg, in_section_next;
    logic                 skip_reg, skip_next;
    logic [WP_W-1:0]      wp_reg, wp_next;

    // report context: section or setting, value length captured at trigger
    logic                 rep_sec_reg, rep_sec_next;
    logic [WP_W-1:0]      rep_len_reg, rep_len_next;

    // readout: phase of the outstanding read (0 name, 1 value) and its index
    logic                 rd_phase_reg, rd_phase_next;
    logic [WP_W-1:0]      rd_idx_reg, rd_idx_next;

    // one-character hold stage: a char is released once it is known whether it ends the run
    logic                 hold_v_reg, hold_v_next;
    itt_pkg::token_kind_t hold_kind_reg, hold_kind_next;
    logic [7:0]           hold_char_reg, hold_char_next;

    // output register
    logic                 out_v_reg, out_v_next;
    itt_pkg::token_kind_t out_kind_reg, out_kind_next;
    logic [7:0]           out_char_reg, out_char_next;
    logic                 out_end_reg, out_end_next;

    // ------------------------------------------------------------------
    // Store interface
    // ------------------------------------------------------------------
    itt_pkg::store_ctl_t  st_ctl;
    logic [7:0]           name_wdata;
    logic [WP_W-1:0]      rd_addr;
    logic [7:0]           name_q;
    logic [7:0]           value_q;

    itt_store #(
        .NAME_DEPTH  (NAME_DEPTH),
        .VALUE_DEPTH (VALUE_DEPTH)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (st_ctl),
        .name_waddr  (wp_reg[NA_W-1:0]),
        .name_wdata  (name_wdata),
        .name_raddr  (rd_addr[NA_W-1:0]),
        .name_rdata  (name_q),
        .value_waddr (wp_reg[VA_W-1:0]),
        .value_wdata (text_byte),
        .value_raddr (rd_addr[VA_W-1:0]),
        .value_rdata (value_q)
    );

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    logic            accept;
    logic            out_free;
    logic            can_take;
    logic            wp_nz;
    logic            wp_in_name;
    logic [WP_W:0]   wp_inc;
    logic [WP_W:0]   rd_idx_inc;
    logic            name_cap_hit;
    logic            value_last;

    assign text_ready   = (state_reg == itt_pkg::ST_IDLE);
    assign accept       = text_valid && text_ready;
    assign out_free     = !out_v_reg || token_ready;
    assign can_take     = !hold_v_reg || out_free;
    assign wp_nz        = (wp_reg != '0);
    assign wp_in_name   = ({1'b0, wp_reg} < (WP_W + 1)'(NAME_DEPTH));
    assign wp_inc       = {1'b0, wp_reg} + 1'b1;
    assign rd_idx_inc   = {1'b0, rd_idx_reg} + 1'b1;
    // names are read as at most NAME_DEPTH-1 characters
    assign name_cap_hit = (rd_idx_inc == (WP_W + 1)'(NAME_DEPTH - 1));
    assign value_last   = (rd_idx_reg == rep_len_reg - 1'b1);

    // ------------------------------------------------------------------
    // State register and datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= itt_pkg::ST_IDLE;
            in_setting_reg <= 1'b0;
            in_section_reg <= 1'b0;
            skip_reg       <= 1'b0;
            wp_reg         <= '0;
            hold_v_reg     <= 1'b0;
            out_v_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            in_setting_reg <= in_setting_next;
            in_section_reg <= in_section_next;
            skip_reg       <= skip_next;
            wp_reg         <= wp_next;
            hold_v_reg     <= hold_v_next;
            out_v_reg      <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rep_sec_reg   <= rep_sec_next;
        rep_len_reg   <= rep_len_next;
        rd_phase_reg  <= rd_phase_next;
        rd_idx_reg    <= rd_idx_next;
        hold_kind_reg <= hold_kind_next;
        hold_char_reg <= hold_char_next;
        out_kind_reg  <= out_kind_next;
        out_char_reg  <= out_char_next;
        out_end_reg   <= out_end_next;
    end

    // ------------------------------------------------------------------
    // Next state: parser in IDLE, readout sequencer otherwise
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        in_setting_next = in_setting_reg;
        in_section_next = in_section_reg;
        skip_next       = skip_reg;
        wp_next         = wp_reg;
        rep_sec_next    = rep_sec_reg;
        rep_len_next    = rep_len_reg;
        rd_phase_next   = rd_phase_reg;
        rd_idx_next     = rd_idx_reg;
        hold_v_next     = hold_v_reg;
        hold_kind_next  = hold_kind_reg;
        hold_char_next  = hold_char_reg;
        out_v_next      = out_v_reg && !token_ready;
        out_kind_next   = out_kind_reg;
        out_char_next   = out_char_reg;
        out_end_next    = out_end_reg;
        st_ctl          = '0;
        name_wdata      = itt_pkg::CH_NUL;
        rd_addr         = '0;

        case (state_reg)
            itt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (skip_reg)
                    begin
                        if (text_byte == itt_pkg::CH_CR || text_byte == itt_pkg::CH_LF ||
                            text_byte == itt_pkg::CH_NUL)
                        begin
                            skip_next = 1'b0;
                            wp_next   = '0;
                        end
                    end
                    else
                    begin
                        case (text_byte)
                            itt_pkg::CH_NUL, itt_pkg::CH_CR, itt_pkg::CH_LF:
                            begin
                                if (in_setting_reg && wp_nz)
                                begin
                                    state_next   = itt_pkg::ST_START;
                                    rep_sec_next = 1'b0;
                                    rep_len_next = wp_reg;
                                end
                                in_setting_next = 1'b0;
                                in_section_next = 1'b0;
                                wp_next         = '0;
                            end
                            itt_pkg::CH_SPACE, itt_pkg::CH_TAB:
                            begin
                                if (in_setting_reg && wp_nz)
                                begin
                                    state_next      = itt_pkg::ST_START;
                                    rep_sec_next    = 1'b0;
                                    rep_len_next    = wp_reg;
                                    in_setting_next = 1'b0;
                                    in_section_next = 1'b0;
                                    skip_next       = 1'b1;
                                end
                                else if (!in_setting_reg && wp_nz && wp_in_name)
                                begin
                                    // terminate the key
                                    st_ctl.name_we = 1'b1;
                                end
                                wp_next = '0;
                            end
                            itt_pkg::CH_LBRACK:
                            begin
                                in_section_next = 1'b1;
                            end
                            itt_pkg::CH_RBRACK:
                            begin
                                if (in_section_reg && wp_nz)
                                begin
                                    st_ctl.name_we = wp_in_name;
                                    state_next     = itt_pkg::ST_START;
                                    rep_sec_next   = 1'b1;
                                end
                                in_setting_next = 1'b0;
                                in_section_next = 1'b0;
                                skip_next       = 1'b1;
                                wp_next         = '0;
                            end
                            itt_pkg::CH_HASH, itt_pkg::CH_SEMI:
                            begin
                                in_setting_next = 1'b0;
                                in_section_next = 1'b0;
                                skip_next       = 1'b1;
                                wp_next         = '0;
                            end
                            itt_pkg::CH_COLON, itt_pkg::CH_EQUAL:
                            begin
                                if (in_section_reg)
                                begin
                                    in_setting_next = 1'b0;
                                    in_section_next = 1'b0;
                                    skip_next       = 1'b1;
                                end
                                else
                                begin
                                    in_setting_next = 1'b1;
                                    st_ctl.name_we  = wp_nz && wp_in_name;
                                end
                                wp_next = '0;
                            end
                            default:
                            begin
                                if (in_setting_reg)
                                begin
                                    st_ctl.value_we =
                                        ({1'b0, wp_reg} < (WP_W + 1)'(VALUE_DEPTH));
                                    if (wp_inc >= (WP_W + 1)'(VALUE_DEPTH))
                                    begin
                                        in_setting_next = 1'b0;
                                        in_section_next = 1'b0;
                                        skip_next       = 1'b1;
                                        wp_next         = '0;
                                    end
                                    else
                                    begin
                                        wp_next = wp_inc[WP_W-1:0];
                                    end
                                end
                                else
                                begin
                                    st_ctl.name_we = wp_in_name;
                                    name_wdata     = text_byte;
                                    if (wp_inc >= (WP_W + 1)'(NAME_DEPTH))
                                    begin
                                        in_setting_next = 1'b0;
                                        in_section_next = 1'b0;
                                        skip_next       = 1'b1;
                                        wp_next         = '0;
                                    end
                                    else
                                    begin
                                        wp_next = wp_inc[WP_W-1:0];
                                    end
                                end
                            end
                        endcase
                    end
                end
            end

            itt_pkg::ST_START:
            begin
                // stores were written at the trigger edge; first name read now
                st_ctl.name_re = 1'b1;
                rd_addr        = '0;
                rd_phase_next  = 1'b0;
                rd_idx_next    = '0;
                state_next     = itt_pkg::ST_READ;
            end

            itt_pkg::ST_READ:
            begin
                // read data stays on the store output until it is consumed
                if (can_take)
                begin
                    if (!rd_phase_reg && name_q == itt_pkg::CH_NUL)
                    begin
                        if (rep_sec_reg)
                        begin
                            if (hold_v_reg)
                            begin
                                out_v_next    = 1'b1;
                                out_kind_next = hold_kind_reg;
                                out_char_next = hold_char_reg;
                                out_end_next  = 1'b1;
                                hold_v_next   = 1'b0;
                            end
                            state_next = itt_pkg::ST_IDLE;
                        end
                        else
                        begin
                            st_ctl.value_re = 1'b1;
                            rd_addr         = '0;
                            rd_phase_next   = 1'b1;
                            rd_idx_next     = '0;
                        end
                    end
                    else
                    begin
                        if (hold_v_reg)
                        begin
                            out_v_next    = 1'b1;
                            out_kind_next = hold_kind_reg;
                            out_char_next = hold_char_reg;
                            out_end_next  = 1'b0;
                        end
                        hold_v_next = 1'b1;
                        if (rd_phase_reg)
                        begin
                            hold_kind_next = itt_pkg::KIND_VALUE;
                            hold_char_next = value_q;
                            if (value_last)
                            begin
                                state_next = itt_pkg::ST_FLUSH;
                            end
                            else
                            begin
                                st_ctl.value_re = 1'b1;
                                rd_addr         = rd_idx_inc[WP_W-1:0];
                                rd_idx_next     = rd_idx_inc[WP_W-1:0];
                            end
                        end
                        else
                        begin
                            hold_kind_next = rep_sec_reg ? itt_pkg::KIND_SECTION
                                                         : itt_pkg::KIND_KEY;
                            hold_char_next = name_q;
                            if (name_cap_hit)
                            begin
                                if (rep_sec_reg)
                                begin
                                    state_next = itt_pkg::ST_FLUSH;
                                end
                                else
                                begin
                                    st_ctl.value_re = 1'b1;
                                    rd_addr         = '0;
                                    rd_phase_next   = 1'b1;
                                    rd_idx_next     = '0;
                                end
                            end
                            else
                            begin
                                st_ctl.name_re = 1'b1;
                                rd_addr        = rd_idx_inc[WP_W-1:0];
                                rd_idx_next    = rd_idx_inc[WP_W-1:0];
                            end
                        end
                    end
                end
            end

            itt_pkg::ST_FLUSH:
            begin
                if (!hold_v_reg)
                begin
                    state_next = itt_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    out_v_next    = 1'b1;
                    out_kind_next = hold_kind_reg;
                    out_char_next = hold_char_reg;
                    out_end_next  = 1'b1;
                    hold_v_next   = 1'b0;
                    state_next    = itt_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = itt_pkg::ST_IDLE;
            end
        endcase
    end

    assign token_valid = out_v_reg;
    assign token_kind  = out_kind_reg;
    assign token_char  = out_char_reg;
    assign run_end     = out_end_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // the hold stage is always drained before a new byte is taken
    a_idle_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == itt_pkg::ST_IDLE) |-> !hold_v_reg)
        else $error("hold stage occupied while accepting bytes");

    // a character that does not end its run means the readout is still busy
    a_open_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !out_end_reg) |-> (state_reg != itt_pkg::ST_IDLE))
        else $error("unterminated run left with the parser idle");

    // value characters belong only to setting reports
    a_value_in_setting: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_v_reg && hold_kind_reg == itt_pkg::KIND_VALUE) |-> !rep_sec_reg)
        else $error("value character inside a section report");

    // a run_end transaction is the last one: the readout has finished the report
    a_end_closes_report: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == itt_pkg::ST_FLUSH && hold_v_reg && out_free)
            |=> (state_reg == itt_pkg::ST_IDLE && out_v_reg && out_end_reg))
        else $error("final character not released with run_end");

endmodule

### hw/rtl/itt_store.sv
// Name and value character stores with registered read ports.
`timescale 1ns / 1ps

module itt_store #(
    parameter int unsigned NAME_DEPTH  = itt_pkg::NAME_DEPTH_DEF,
    parameter int unsigned VALUE_DEPTH = itt_pkg::VALUE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  itt_pkg::store_ctl_t            ctl,
    input  logic [$clog2(NAME_DEPTH)-1:0]  name_waddr,
    input  logic [7:0]                     name_wdata,
    input  logic [$clog2(NAME_DEPTH)-1:0]  name_raddr,
    output logic [7:0]                     name_rdata,
    input  logic [$clog2(VALUE_DEPTH)-1:0] value_waddr,
    input  logic [7:0]                     value_wdata,
    input  logic [$clog2(VALUE_DEPTH)-1:0] value_raddr,
    output logic [7:0]                     value_rdata
);

    logic [7:0]            name_mem [NAME_DEPTH];
    logic [7:0]            value_mem [VALUE_DEPTH];
    logic [NAME_DEPTH-1:0] name_vld_reg;
    logic [7:0]            name_rdata_reg;
    logic [7:0]            value_rdata_reg;

    // unwritten name entries read as zero (terminator)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_vld_reg <= '0;
        end
        else if (ctl.name_we)
        begin
            name_vld_reg[name_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.name_we)
        begin
            name_mem[name_waddr] <= name_wdata;
        end
        if (ctl.name_re)
        begin
            name_rdata_reg <= name_vld_reg[name_raddr] ? name_mem[name_raddr] : 8'h00;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.value_we)
        begin
            value_mem[value_waddr] <= value_wdata;
        end
        if (ctl.value_re)
        begin
            value_rdata_reg <= value_mem[value_raddr];
        end
    end

    assign name_rdata  = name_rdata_reg;
    assign value_rdata = value_rdata_reg;

endmodule

### bench/tb_top.sv
// Self-checking testbench for the INI text tokenizer: scripted and random text.
`timescale 1ns / 1ps

module tb_top;

    localparam int NAME_DEPTH   = itt_pkg::NAME_DEPTH_DEF;
    localparam int VALUE_DEPTH  = itt_pkg::VALUE_DEPTH_DEF;
    localparam int RANDOM_BYTES = 320;
    localparam int MAX_GAP      = 18;
    localparam int HOLD_CYCLES  = 400;   // long output stall, fills the readout path
    localparam int STALL_LIMIT  = 3000;  // cycles with no transaction on either side
    localparam int SETTLE       = 100;   // margin after the drain, longer than the readout of the longest report

    // One reported character as it leaves the block.
    typedef struct packed {
        itt_pkg::token_kind_t kind;
        logic [7:0]           ch;
        logic                 last;
    } char_token_t;

    logic       clk;
    logic       rst_n;
    logic       text_valid;
    logic       text_ready;
    logic [7:0] text_byte;
    logic       token_valid;
    logic       token_ready;
    logic [1:0] token_kind;
    logic [7:0] token_char;
    logic       run_end;

    ini_text_tokenizer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_valid  (text_valid),
        .text_ready  (text_ready),
        .text_byte   (text_byte),
        .token_valid (token_valid),
        .token_ready (token_ready),
        .token_kind  (token_kind),
        .token_char  (token_char),
        .run_end     (run_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Parser mirror: name store, value store, position and line flags.
    // ------------------------------------------------------------------
    logic [7:0] name_chars  [NAME_DEPTH];
    logic [7:0] value_chars [VALUE_DEPTH];
    int         name_len;
    int         pos;
    bit         setting_open;
    bit         section_open;
    bit         line_skip;

    char_token_t fresh_tokens[$];     // characters caused by the latest byte
    char_token_t pending_tokens[$];   // characters still owed by the block

    int  mismatches;
    int  chars_checked;
    int  reports_seen;
    int  bytes_sent;
    int  scripted_bytes;
    int  long_holds;
    int  stall_cycles;
    bit  quiet_sender;
    bit  quiet_sink;
    bit  hold_off_pending;

    function automatic char_token_t make_token(itt_pkg::token_kind_t kind, logic [7:0] ch);
        char_token_t t;
        t.kind = kind;
        t.ch   = ch;
        t.last = 1'b0;
        return t;
    endfunction

    // Name length is the index of the first terminator, capped one short of the depth.
    function automatic void name_write(int p, logic [7:0] c);
        int n;
        if (p < NAME_DEPTH)
        begin
            name_chars[p] = c;
            n = 0;
            while (n < NAME_DEPTH - 1 && name_chars[n] != 8'h00)
                n++;
            name_len = n;
        end
    endfunction

    function automatic void clear_line();
        setting_open = 1'b0;
        section_open = 1'b0;
        line_skip    = 1'b0;
        pos          = 0;
    endfunction

    function automatic void skip_rest();
        clear_line();
        line_skip = 1'b1;
    endfunction

    // Name characters first, then (settings only) the value; last one flagged.
    function automatic void emit_report(bit as_section);
        for (int i = 0; i < name_len; i++)
            fresh_tokens.push_back(make_token(as_section ? itt_pkg::KIND_SECTION
                                                         : itt_pkg::KIND_KEY,
                                              name_chars[i]));
        if (!as_section)
            for (int i = 0; i < pos && i < VALUE_DEPTH; i++)
                fresh_tokens.push_back(make_token(itt_pkg::KIND_VALUE, value_chars[i]));
        if (fresh_tokens.size() > 0)
            fresh_tokens[fresh_tokens.size() - 1].last = 1'b1;
    endfunction

    function automatic void tokenize_byte(logic [7:0] c);
        fresh_tokens.delete();
        if (line_skip)
        begin
            // end of stream also ends a skipped line
            if (c == itt_pkg::CH_CR || c == itt_pkg::CH_LF || c == itt_pkg::CH_NUL)
                clear_line();
            return;
        end
        case (c)
            itt_pkg::CH_NUL, itt_pkg::CH_CR, itt_pkg::CH_LF:
            begin
                if (setting_open && pos != 0)
                    emit_report(1'b0);
                clear_line();
            end
            itt_pkg::CH_SPACE, itt_pkg::CH_TAB:
            begin
                if (setting_open && pos != 0)
                begin
                    emit_report(1'b0);
                    skip_rest();
                end
                else
                begin
                    // whitespace after a key terminates it
                    if (!setting_open && pos != 0)
                        name_write(pos, itt_pkg::CH_NUL);
                    pos = 0;
                end
            end
            itt_pkg::CH_LBRACK:
                section_open = 1'b1;
            itt_pkg::CH_RBRACK:
            begin
                if (section_open && pos > 0)
                begin
                    name_write(pos, itt_pkg::CH_NUL);
                    emit_report(1'b1);
                end
                skip_rest();
            end
            itt_pkg::CH_HASH, itt_pkg::CH_SEMI:
                skip_rest();
            itt_pkg::CH_COLON, itt_pkg::CH_EQUAL:
            begin
                if (section_open)
                    skip_rest();
                else
                begin
                    // a nonzero position writes a terminator, even mid-value
                    setting_open = 1'b1;
                    if (pos != 0)
                        name_write(pos, itt_pkg::CH_NUL);
                    pos = 0;
                end
            end
            default:
            begin
                if (setting_open)
                begin
                    if (pos < VALUE_DEPTH)
                        value_chars[pos] = c;
                    pos++;
                    if (pos >= VALUE_DEPTH)
                        skip_rest();
                end
                else
                begin
                    name_write(pos, c);
                    pos++;
                    if (pos >= NAME_DEPTH)
                        skip_rest();
                end
            end
        endcase
    endfunction

    // Expectation written out by hand for a scripted row.
    function automatic void typed_report(bit sect, string key, string val);
        int start;
        start = pending_tokens.size();
        for (int i = 0; i < key.len(); i++)
            pending_tokens.push_back(make_token(sect ? itt_pkg::KIND_SECTION
                                                     : itt_pkg::KIND_KEY, key[i]));
        for (int i = 0; i < val.len(); i++)
            pending_tokens.push_back(make_token(itt_pkg::KIND_VALUE, val[i]));
        if (pending_tokens.size() > start)
            pending_tokens[pending_tokens.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Text side: one byte per transaction, random gap drawn per byte.
    // Called at a clock edge; returns at the edge that accepted the byte.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input bit typed, input bit sect,
                             input string key, input string val);
        int gap;
        gap = quiet_sender ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            text_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_valid <= 1'b1;
        text_byte  <= b;
        do
            @(posedge clk);
        while (!text_ready);
        // Predict at the accepting edge; no character of this byte can leave yet.
        tokenize_byte(b);
        if (typed)
            typed_report(sect, key, val);
        else
            foreach (fresh_tokens[i])
                pending_tokens.push_back(fresh_tokens[i]);
        bytes_sent++;
    endtask

    task automatic drain_wait();
        while (pending_tokens.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Random text generation
    // ------------------------------------------------------------------
    logic [7:0] line_bytes[$];

    function automatic bit is_special(logic [7:0] c);
        case (c)
            itt_pkg::CH_NUL, itt_pkg::CH_TAB, itt_pkg::CH_LF, itt_pkg::CH_CR,
            itt_pkg::CH_SPACE, itt_pkg::CH_HASH, itt_pkg::CH_COLON, itt_pkg::CH_SEMI,
            itt_pkg::CH_EQUAL, itt_pkg::CH_LBRACK, itt_pkg::CH_RBRACK:
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    // Mostly lowercase letters, otherwise any byte the parser stores as-is.
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        if ($urandom_range(0, 3) != 0)
            return 8'h61 + 8'($urandom_range(0, 25));
        do
            c = 8'($urandom_range(1, 255));
        while (is_special(c));
        return c;
    endfunction

    // Anything that does not end a line.
    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == itt_pkg::CH_LF || c == itt_pkg::CH_CR);
        return c;
    endfunction

    function automatic void push_eol();
        case ($urandom_range(0, 2))
            0: line_bytes.push_back(itt_pkg::CH_LF);
            1: line_bytes.push_back(itt_pkg::CH_CR);
            default:
            begin
                line_bytes.push_back(itt_pkg::CH_CR);
                line_bytes.push_back(itt_pkg::CH_LF);
            end
        endcase
    endfunction

    function automatic int draw_len(int short_max);
        case ($urandom_range(0, 15))
            0: return 0;
            1: return $urandom_range(29, 33);  // around the store depth
            default: return $urandom_range(1, short_max);
        endcase
    endfunction

    // Mostly well-formed lines with random content; some comments and noise.
    function automatic void compose_line();
        int pick;
        int n;
        int sep_at;
        pick = $urandom_range(0, 99);
        line_bytes.delete();
        if (pick < 30)
        begin
            n      = draw_len(6);
            sep_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n) : -1;
            if ($urandom_range(0, 7) != 0)
                line_bytes.push_back(itt_pkg::CH_LBRACK);   // else a stray ']'
            for (int i = 0; i < n; i++)
            begin
                if (i == sep_at)
                    line_bytes.push_back($urandom_range(0, 1) ? itt_pkg::CH_EQUAL
                                                              : itt_pkg::CH_COLON);
                line_bytes.push_back(plain_char());
            end
            line_bytes.push_back(itt_pkg::CH_RBRACK);
            push_eol();
        end
        else if (pick < 75)
        begin
            if ($urandom_range(0, 5) == 0)
                line_bytes.push_back(itt_pkg::CH_SPACE);
            n = draw_len(8);
            for (int i = 0; i < n; i++)
                line_bytes.push_back(plain_char());
            if ($urandom_range(0, 5) == 0)
                line_bytes.push_back(itt_pkg::CH_TAB);
            line_bytes.push_back($urandom_range(0, 1) ? itt_pkg::CH_EQUAL
                                                      : itt_pkg::CH_COLON);
            n = draw_len(8);
            for (int i = 0; i < n; i++)
                line_bytes.push_back(plain_char());
            case ($urandom_range(0, 7))
                4:
                begin
                    line_bytes.push_back(itt_pkg::CH_SPACE);
                    repeat ($urandom_range(0, 3)) line_bytes.push_back(junk_char());
                    push_eol();
                end
                5:
                begin
                    line_bytes.push_back(itt_pkg::CH_TAB);
                    push_eol();
                end
                6: line_bytes.push_back(itt_pkg::CH_NUL);
                7: ;   // runs on into the next line
                default: push_eol();
            endcase
        end
        else if (pick < 87)
        begin
            line_bytes.push_back($urandom_range(0, 1) ? itt_pkg::CH_HASH
                                                      : itt_pkg::CH_SEMI);
            repeat ($urandom_range(0, 6)) line_bytes.push_back(junk_char());
            if ($urandom_range(0, 3) == 0)
                line_bytes.push_back(itt_pkg::CH_NUL);
            else
                push_eol();
        end
        else
        begin
            repeat ($urandom_range(1, 10)) line_bytes.push_back(8'($urandom_range(0, 255)));
            push_eol();
        end
    endfunction

    // ------------------------------------------------------------------
    // Token side: ready drawn per transaction, with one long hold-off on request.
    // ------------------------------------------------------------------
    initial
    begin
        int hold;
        token_ready = 1'b0;
        quiet_sink  = 1'b0;
        long_holds  = 0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (hold_off_pending)
            begin
                hold_off_pending = 1'b0;
                hold = HOLD_CYCLES;
                long_holds++;
            end
            else
                hold = quiet_sink ? 0 : $urandom_range(0, MAX_GAP);
            if (hold > 0)
            begin
                token_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            token_ready <= 1'b1;
            do
                @(posedge clk);
            while (!token_valid);
            if ($urandom_range(0, 24) == 0)
                quiet_sink = !quiet_sink;
        end
    end

    // Compare each character taken with the oldest one owed.
    always @(posedge clk)
    begin
        char_token_t want;
        if (rst_n && token_valid && token_ready)
        begin
            chars_checked++;
            if (run_end)
                reports_seen++;
            if (pending_tokens.size() == 0)
            begin
                if (mismatches < 10)
                    $display("tb_top: unexpected character: kind %0d char %02h end %0b",
                             token_kind, token_char, run_end);
                mismatches++;
            end
            else
            begin
                want = pending_tokens.pop_front();
                if (token_kind !== want.kind || token_char !== want.ch
                    || run_end !== want.last)
                begin
                    if (mismatches < 10)
                        $display({"tb_top: mismatch at character %0d: want kind %0d char %02h",
                                  " end %0b, got kind %0d char %02h end %0b"},
                                 chars_checked, want.kind, want.ch, want.last,
                                 token_kind, token_char, run_end);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: a long run with no transaction on either side means a hang.
    always @(posedge clk)
    begin
        if (!rst_n || (text_valid && text_ready) || (token_valid && token_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb_top: watchdog, no transaction for %0d cycles", stall_cycles);
            $display("tb_top: done, errors");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Scripted rows: byte, and where obvious the report it must produce.
    // ------------------------------------------------------------------
    logic [7:0] drill_byte[$];
    bit         drill_typed[$];
    bit         drill_sect[$];
    string      drill_key[$];
    string      drill_val[$];

    function automatic void drill(logic [7:0] b, bit typed, bit sect, string key,
                                  string val);
        drill_byte.push_back(b);
        drill_typed.push_back(typed);
        drill_sect.push_back(sect);
        drill_key.push_back(key);
        drill_val.push_back(val);
    endfunction

    initial
    begin
        bit paused;
        rst_n            = 1'b0;
        text_valid       = 1'b0;
        text_byte        = 8'h00;
        mismatches       = 0;
        chars_checked    = 0;
        reports_seen     = 0;
        bytes_sent       = 0;
        stall_cycles     = 0;
        quiet_sender     = 1'b0;
        hold_off_pending = 1'b0;
        paused           = 1'b0;

        foreach (name_chars[i])
            name_chars[i] = 8'h00;
        foreach (value_chars[i])
            value_chars[i] = 8'h00;
        name_len = 0;
        clear_line();

        // Empty key right after reset: value characters only, ended by byte 0.
        drill(itt_pkg::CH_EQUAL,  1'b0, 1'b0, "",  "");
        drill("z",                1'b0, 1'b0, "",  "");
        drill(itt_pkg::CH_NUL,    1'b1, 1'b0, "",  "z");
        // Stray ']' reports nothing and skips the line.
        drill(itt_pkg::CH_RBRACK, 1'b1, 1'b0, "",  "");
        drill(itt_pkg::CH_LF,     1'b0, 1'b0, "",  "");
        // Plain section.
        drill(itt_pkg::CH_LBRACK, 1'b0, 1'b0, "",  "");
        drill("s",                1'b0, 1'b0, "",  "");
        drill(itt_pkg::CH_RBRACK, 1'b1, 1'b1, "s", "");
        drill(itt_pkg::CH_CR,     1'b0, 1'b0, "",  "");
        // Setting with ':' ended by a space; top bit set in the value; rest skipped.
        drill("k",                1'b0, 1'b0, "",  "");
        drill(itt_pkg::CH_COLON,  1'b0, 1'b0, "",  "");
        drill("v",                1'b0, 1'b0, "",  "");
        drill(8'hFF,              1'b0, 1'b0, "",  "");
        drill(itt_pkg::CH_SPACE,  1'b1, 1'b0, "k", "v\377");
        drill("x",                1'b0, 1'b0, "",  "");
        drill(itt_pkg::CH_LF,     1'b0, 1'b0, "",  "");
        // Key left out: the stale name is reused; tab ends the value.
        drill(itt_pkg::CH_EQUAL,  1'b0, 1'b0, "",  "");
        drill("w",                1'b0, 1'b0, "",  "");
        drill(itt_pkg::CH_TAB,    1'b1, 1'b0, "k", "w");
        drill(itt_pkg::CH_LF,     1'b0, 1'b0, "",  "");
        // Both comment marks.
        drill(itt_pkg::CH_HASH,   1'b0, 1'b0, "",  "");
        drill(itt_pkg::CH_EQUAL,  1'b0, 1'b0, "",  "");
        drill(itt_pkg::CH_LF,     1'b0, 1'b0, "",  "");
        drill(itt_pkg::CH_SEMI,   1'b0, 1'b0, "",  "");
        drill(itt_pkg::CH_LF,     1'b0, 1'b0, "",  "");
        // Separator inside a section, then end of stream while skipping.
        drill(itt_pkg::CH_LBRACK, 1'b0, 1'b0, "",  "");
        drill(itt_pkg::CH_EQUAL,  1'b0, 1'b0, "",  "");
        drill(itt_pkg::CH_NUL,    1'b0, 1'b0, "",  "");

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (drill_byte[i])
            send_byte(drill_byte[i], drill_typed[i], drill_sect[i], drill_key[i],
                      drill_val[i]);
        scripted_bytes = bytes_sent;
        text_valid <= 1'b0;
        drain_wait();

        // Random text. Opens with a back-to-back burst while the output side
        // holds off, so the block backs up and stalls its input.
        quiet_sender     = 1'b1;
        hold_off_pending = 1'b1;
        while (bytes_sent - scripted_bytes < RANDOM_BYTES)
        begin
            if (!paused && bytes_sent - scripted_bytes >= RANDOM_BYTES / 2)
            begin
                // sender stops until the block has delivered everything
                paused = 1'b1;
                text_valid <= 1'b0;
                drain_wait();
            end
            compose_line();
            foreach (line_bytes[i])
                send_byte(line_bytes[i], 1'b0, 1'b0, "", "");
            if ($urandom_range(0, 4) == 0)
                quiet_sender = !quiet_sender;
        end
        text_valid <= 1'b0;

        drain_wait();
        repeat (SETTLE) @(posedge clk);

        $display("tb_top: %0d bytes in (%0d scripted), %0d characters in %0d reports checked",
                 bytes_sent, scripted_bytes, chars_checked, reports_seen);
        $display("tb_top: %0d long output stall(s), %0d mismatches",
                 long_holds, mismatches);
        if (mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
